// ----- src/tdjm_pkg.sv -----
`timescale 1ns / 1ps

package tdjm_pkg;

	localparam int unsigned RATE_W    = 13;
	localparam int unsigned LAT_W     = 16;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [RATE_W-1:0] RATE_FAST_RST = 13'd10;
	localparam logic [RATE_W-1:0] RATE_SLOW_RST = 13'd100;
	localparam logic              LED_AUTO_RST  = 1'b1;
	localparam logic [LAT_W-1:0]  LAT_NONE      = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_SET_LED = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATE_FAST = 2'd0,
		CFG_RATE_SLOW = 2'd1,
		CFG_LED_AUTO  = 2'd2
	} cfg_idx_t;

	// decoded item, qualified by the advance of the item stage
	typedef struct packed {
		logic tick;
		logic clr;
		logic set_led;
	} item_ctl_t;

endpackage

// ----- src/tdjm_divider.sv -----
`timescale 1ns / 1ps

module tdjm_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              clr,
	input  logic [tdjm_pkg::RATE_W-1:0]       rate,
	output logic                              evt,
	output logic [tdjm_pkg::CNT_W-1:0]        total_nxt
);

	logic [tdjm_pkg::RATE_W-1:0] acc_q;
	logic [tdjm_pkg::CNT_W-1:0]  total_q;
	logic [tdjm_pkg::RATE_W:0]   acc_inc;
	logic                        fire;

	assign acc_inc   = {1'b0, acc_q} + {{tdjm_pkg::RATE_W{1'b0}}, 1'b1};
	// a rate of zero fires on every tick, like a rate of one
	assign fire      = acc_inc >= {1'b0, rate};
	assign evt       = step & fire;
	assign total_nxt = evt ? total_q + 32'd1 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
		end else begin
			if (clr) begin
				acc_q <= '0;
			end else if (step) begin
				acc_q <= fire ? '0 : acc_inc[tdjm_pkg::RATE_W-1:0];
			end
			total_q <= total_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_fire_wraps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		evt |=> acc_q == '0)
		else $error("divider accumulator not cleared after event");
`endif

endmodule

// ----- src/tdjm_stats.sv -----
`timescale 1ns / 1ps

module tdjm_stats (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tdjm_pkg::item_ctl_t           ctl,
	input  logic [tdjm_pkg::LAT_W-1:0]    latency,
	output logic [tdjm_pkg::LAT_W-1:0]    min_nxt,
	output logic [tdjm_pkg::LAT_W-1:0]    max_nxt,
	output logic [tdjm_pkg::CNT_W-1:0]    sum_nxt,
	output logic [tdjm_pkg::CNT_W-1:0]    cnt_nxt
);

	logic [tdjm_pkg::LAT_W-1:0] min_q;
	logic [tdjm_pkg::LAT_W-1:0] max_q;
	logic [tdjm_pkg::CNT_W-1:0] sum_q;
	logic [tdjm_pkg::CNT_W-1:0] cnt_q;

	always_comb begin
		min_nxt = min_q;
		max_nxt = max_q;
		sum_nxt = sum_q;
		cnt_nxt = cnt_q;
		priority if (ctl.tick) begin
			if (latency < min_q) begin
				min_nxt = latency;
			end
			if (latency > max_q) begin
				max_nxt = latency;
			end
			sum_nxt = sum_q + {{(tdjm_pkg::CNT_W - tdjm_pkg::LAT_W){1'b0}}, latency};
			cnt_nxt = cnt_q + 32'd1;
		end else if (ctl.clr) begin
			min_nxt = tdjm_pkg::LAT_NONE;
			max_nxt = '0;
			sum_nxt = '0;
			cnt_nxt = '0;
		end else begin
			min_nxt = min_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= tdjm_pkg::LAT_NONE;
			max_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			min_q <= min_nxt;
			max_q <= max_nxt;
			sum_q <= sum_nxt;
			cnt_q <= cnt_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> min_q <= max_q)
		else $error("latency minimum above maximum with samples present");
`endif

endmodule

// ----- src/tick_divider_jitter_monitor_top.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  s_tuser op, s_tdata latency and led level
// m_        out        m_tvalid / m_tready  m_tdata full status word
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word per cycle while m_ is not stalled; between the s_ acceptance edge and m_tvalid lie
// the item register, then the result register; state updates as the item leaves the item register
// arst_n resets all state but the item payload and m_tdata; rates come up at 10 and 100, auto led on
// a stall on m_ holds the result and the item register; s_tready drops only when both are full
// cfg_ready is always high; writes are meant for when no word is in flight

module tick_divider_jitter_monitor_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // latency[15:0], led_level[16], zero pad
	input  logic [1:0]                    s_tuser,   // op[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tick_count[31:0], fast_event[32], slow_event[33], fast_events[65:34],
	// slow_events[97:66], led[98], jitter_min[114:99], jitter_max[130:115],
	// jitter_sum[162:131], sample_count[194:163], zero pad
	output logic [199:0]                  m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tdjm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tdjm_pkg::RATE_W-1:0]   cfg_data
);

	// item register
	logic                       item_valid_s1;
	tdjm_pkg::op_t              item_op_s1;
	logic [tdjm_pkg::LAT_W-1:0] item_lat_s1;
	logic                       item_lvl_s1;

	logic                       out_valid_q;
	logic [199:0]               out_data_q;

	logic [tdjm_pkg::RATE_W-1:0] rate_fast_q;
	logic [tdjm_pkg::RATE_W-1:0] rate_slow_q;
	logic                        led_auto_q;
	logic                        led_q;
	logic [tdjm_pkg::CNT_W-1:0]  ticks_q;

	logic                       advance;
	logic                       cfg_wr;
	tdjm_pkg::item_ctl_t        ctl;
	logic                       fast_clr;
	logic                       slow_clr;
	logic                       fast_evt;
	logic                       slow_evt;
	logic [tdjm_pkg::CNT_W-1:0] fast_total_nxt;
	logic [tdjm_pkg::CNT_W-1:0] slow_total_nxt;
	logic [tdjm_pkg::LAT_W-1:0] min_nxt;
	logic [tdjm_pkg::LAT_W-1:0] max_nxt;
	logic [tdjm_pkg::CNT_W-1:0] sum_nxt;
	logic [tdjm_pkg::CNT_W-1:0] cnt_nxt;
	logic [tdjm_pkg::CNT_W-1:0] ticks_nxt;
	logic                       led_nxt;

	assign advance   = item_valid_s1 & (~out_valid_q | m_tready);
	assign s_tready  = ~item_valid_s1 | advance;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign fast_clr  = cfg_wr & (cfg_index == tdjm_pkg::CFG_RATE_FAST);
	assign slow_clr  = cfg_wr & (cfg_index == tdjm_pkg::CFG_RATE_SLOW);

	always_comb begin
		ctl = '0;
		if (advance) begin
			unique case (item_op_s1)
				tdjm_pkg::OP_TICK:    ctl.tick    = 1'b1;
				tdjm_pkg::OP_CLEAR:   ctl.clr     = 1'b1;
				tdjm_pkg::OP_SET_LED: ctl.set_led = 1'b1;
				default:              ctl         = '0;
			endcase
		end
	end

	tdjm_divider u_fast (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (ctl.tick),
		.clr       (fast_clr),
		.rate      (rate_fast_q),
		.evt       (fast_evt),
		.total_nxt (fast_total_nxt)
	);

	tdjm_divider u_slow (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (ctl.tick),
		.clr       (slow_clr),
		.rate      (rate_slow_q),
		.evt       (slow_evt),
		.total_nxt (slow_total_nxt)
	);

	tdjm_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.latency (item_lat_s1),
		.min_nxt (min_nxt),
		.max_nxt (max_nxt),
		.sum_nxt (sum_nxt),
		.cnt_nxt (cnt_nxt)
	);

	assign ticks_nxt = ctl.tick ? ticks_q + 32'd1 : ticks_q;

	always_comb begin
		priority if (ctl.set_led) begin
			led_nxt = item_lvl_s1;
		end else if (slow_evt && led_auto_q) begin
			led_nxt = ~led_q;
		end else begin
			led_nxt = led_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
			rate_fast_q   <= tdjm_pkg::RATE_FAST_RST;
			rate_slow_q   <= tdjm_pkg::RATE_SLOW_RST;
			led_auto_q    <= tdjm_pkg::LED_AUTO_RST;
			led_q         <= 1'b0;
			ticks_q       <= '0;
		end else begin
			if (s_tready) begin
				item_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (fast_clr) begin
				rate_fast_q <= cfg_data;
			end
			if (slow_clr) begin
				rate_slow_q <= cfg_data;
			end
			if (cfg_wr && cfg_index == tdjm_pkg::CFG_LED_AUTO) begin
				led_auto_q <= cfg_data[0];
			end
			led_q   <= led_nxt;
			ticks_q <= ticks_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_op_s1  <= tdjm_pkg::op_t'(s_tuser[1:0]);
			item_lat_s1 <= s_tdata[15:0];
			item_lvl_s1 <= s_tdata[16];
		end
		if (advance) begin
			out_data_q <= {5'd0, cnt_nxt, sum_nxt, max_nxt, min_nxt, led_nxt,
				slow_total_nxt, fast_total_nxt, slow_evt, fast_evt, ticks_nxt};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_tick_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tick |=> m_tdata[31:0] == $past(ticks_q) + 32'd1)
		else $error("reported tick count does not follow the tick");

	a_led_held_manual: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !ctl.set_led && !led_auto_q) |=> led_q == $past(led_q))
		else $error("led changed with auto mode off");

	a_events_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !ctl.tick) |=> (m_tdata[32] == 1'b0 && m_tdata[33] == 1'b0))
		else $error("event flag set on a non-tick word");
`endif

endmodule
